// ===== hw/rtl/scti_pkg.sv =====
// Shared types, constants and the quarter-wave table for the sine/cosine interpolator.
// Used by scti_pipe_ctl, scti_wave_path and the top level; depends on nothing.
package scti_pkg;

    localparam int PHASE_W = 16;
    localparam int SEG_W   = 8;
    localparam int FRAC_W  = 8;
    localparam int IDX_W   = 7;   // table index 0..64
    localparam int TAB_W   = 16;  // table entry 0..32767
    localparam int PT_W    = 17;  // signed end point after quadrant sign
    localparam int ACC_W   = 26;  // full-precision sum before the output cut
    localparam int OUT_W   = 24;

    localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'h4000;
    localparam logic [IDX_W-1:0]   IDX_EDGE     = 7'd64;
    localparam logic [IDX_W-1:0]   IDX_EDGE_M1  = 7'd63;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sd8388352;

    // Per-stage load enables from the pipeline control
    typedef struct packed {
        logic ld_s1;
        logic ld_s2;
        logic ld_s3;
        logic ld_s4;
    } scti_pipe_en_t;

    // Quarter-wave sine, Q1.15, entries 0..64; unused codes read zero
    function automatic logic [TAB_W-1:0] quarter_wave(input logic [IDX_W-1:0] idx);
        logic [TAB_W-1:0] val;
        case (idx)
            7'd0:  val = 16'd0;
            7'd1:  val = 16'd804;
            7'd2:  val = 16'd1608;
            7'd3:  val = 16'd2410;
            7'd4:  val = 16'd3212;
            7'd5:  val = 16'd4011;
            7'd6:  val = 16'd4808;
            7'd7:  val = 16'd5602;
            7'd8:  val = 16'd6393;
            7'd9:  val = 16'd7179;
            7'd10: val = 16'd7962;
            7'd11: val = 16'd8739;
            7'd12: val = 16'd9512;
            7'd13: val = 16'd10278;
            7'd14: val = 16'd11039;
            7'd15: val = 16'd11793;
            7'd16: val = 16'd12539;
            7'd17: val = 16'd13279;
            7'd18: val = 16'd14010;
            7'd19: val = 16'd14732;
            7'd20: val = 16'd15446;
            7'd21: val = 16'd16151;
            7'd22: val = 16'd16846;
            7'd23: val = 16'd17530;
            7'd24: val = 16'd18204;
            7'd25: val = 16'd18868;
            7'd26: val = 16'd19519;
            7'd27: val = 16'd20159;
            7'd28: val = 16'd20787;
            7'd29: val = 16'd21403;
            7'd30: val = 16'd22005;
            7'd31: val = 16'd22594;
            7'd32: val = 16'd23170;
            7'd33: val = 16'd23731;
            7'd34: val = 16'd24279;
            7'd35: val = 16'd24811;
            7'd36: val = 16'd25329;
            7'd37: val = 16'd25832;
            7'd38: val = 16'd26319;
            7'd39: val = 16'd26790;
            7'd40: val = 16'd27245;
            7'd41: val = 16'd27683;
            7'd42: val = 16'd28105;
            7'd43: val = 16'd28510;
            7'd44: val = 16'd28898;
            7'd45: val = 16'd29268;
            7'd46: val = 16'd29621;
            7'd47: val = 16'd29956;
            7'd48: val = 16'd30273;
            7'd49: val = 16'd30571;
            7'd50: val = 16'd30852;
            7'd51: val = 16'd31113;
            7'd52: val = 16'd31356;
            7'd53: val = 16'd31580;
            7'd54: val = 16'd31785;
            7'd55: val = 16'd31971;
            7'd56: val = 16'd32137;
            7'd57: val = 16'd32285;
            7'd58: val = 16'd32412;
            7'd59: val = 16'd32521;
            7'd60: val = 16'd32609;
            7'd61: val = 16'd32678;
            7'd62: val = 16'd32728;
            7'd63: val = 16'd32757;
            7'd64: val = 16'd32767;
            default: val = 16'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== hw/rtl/scti_pipe_ctl.sv =====
// Valid bits and load enables for the four-stage interpolator pipeline.
// Depends on scti_pkg (scti_pipe_en_t).
module scti_pipe_ctl
    import scti_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output scti_pipe_en_t en
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    // A stage moves when it is empty or its successor moves; bubbles collapse
    always_comb
    begin
        adv4 = !v4_reg || !out_stall;
        adv3 = !v3_reg || adv4;
        adv2 = !v2_reg || adv3;
        adv1 = !v1_reg || adv2;
    end

    assign en.ld_s1 = adv1;
    assign en.ld_s2 = adv2;
    assign en.ld_s3 = adv3;
    assign en.ld_s4 = adv4;

    assign in_stall  = !adv1;
    assign out_valid = v4_reg;

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= in_valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
            if (adv4)
                v4_reg <= v3_reg;
        end
    end

endmodule

// ===== hw/rtl/scti_wave_path.sv =====
// Datapath for one interpolated sine: fold, table read, multiply, sum.
// Depends on scti_pkg (table function, widths, scti_pipe_en_t).
module scti_wave_path
    import scti_pkg::*;
(
    input  logic                    clk,
    input  scti_pipe_en_t           en,
    input  logic [PHASE_W-1:0]      phase,
    output logic signed [OUT_W-1:0] value
);

    // Stage 1: quadrant fold into table indexes
    logic [SEG_W-1:0]  seg;
    logic [5:0]        seg_off;
    logic [IDX_W-1:0]  lo_next, hi_next;
    logic [IDX_W-1:0]  lo_reg, hi_reg;
    logic              neg_reg;
    logic [FRAC_W-1:0] frac1_reg;

    assign seg     = phase[PHASE_W-1 -: SEG_W];
    assign seg_off = seg[5:0];

    // Odd quadrants run the table backward, from the edge entry down
    always_comb
    begin
        if (seg[6])
        begin
            lo_next = IDX_EDGE - {1'b0, seg_off};
            hi_next = IDX_EDGE_M1 - {1'b0, seg_off};
        end
        else
        begin
            lo_next = {1'b0, seg_off};
            hi_next = {1'b0, seg_off} + 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.ld_s1)
        begin
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            neg_reg   <= seg[7];
            frac1_reg <= phase[FRAC_W-1:0];
        end
    end

    // Stage 2: table read and sign of the upper half turn
    logic signed [PT_W-1:0] t1_next, t2_next;
    logic signed [PT_W-1:0] t1_reg, t2_reg;
    logic [FRAC_W-1:0]      frac2_reg;

    always_comb
    begin
        t1_next = $signed({1'b0, quarter_wave(lo_reg)});
        t2_next = $signed({1'b0, quarter_wave(hi_reg)});
        if (neg_reg)
        begin
            t1_next = -t1_next;
            t2_next = -t2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.ld_s2)
        begin
            t1_reg    <= t1_next;
            t2_reg    <= t2_next;
            frac2_reg <= frac1_reg;
        end
    end

    // Stage 3: slope times fraction, base point scaled by 256
    logic signed [PT_W-1:0]  diff;
    logic signed [ACC_W-1:0] prod_next, base_next;
    logic signed [ACC_W-1:0] prod_reg, base_reg;

    assign diff      = t2_reg - t1_reg;
    assign prod_next = ACC_W'(diff) * ACC_W'($signed({1'b0, frac2_reg}));
    assign base_next = {t1_reg[PT_W-1], t1_reg, {FRAC_W{1'b0}}};

    always_ff @(posedge clk)
    begin
        if (en.ld_s3)
        begin
            prod_reg <= prod_next;
            base_reg <= base_next;
        end
    end

    // Stage 4: exact sum, cut to the output width
    logic signed [ACC_W-1:0] sum;
    logic signed [OUT_W-1:0] value_reg;

    assign sum = base_reg + prod_reg;

    always_ff @(posedge clk)
    begin
        if (en.ld_s4)
            value_reg <= sum[OUT_W-1:0];
    end

    assign value = value_reg;

endmodule

// ===== hw/rtl/sine_cosine_table_interpolator_top.sv =====
// Sine/cosine from a 16-bit phase by quarter-wave table and linear interpolation.
// Each accepted item passes through registered fold, table, multiply and sum stages.
// Throughput: one item per cycle unless in_stall is set; each stage holds one item
// and empty stages fill while the output is stalled. in_stall follows out_stall
// through the full stages. Reset (rst_n, async, active low) clears the valid bits
// only; no clearing pass. Depends on scti_pkg, scti_pipe_ctl and scti_wave_path.
module sine_cosine_table_interpolator_top
    import scti_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [PHASE_W-1:0]      phase,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] sine_value,
    output logic signed [OUT_W-1:0] cosine_value
);

    scti_pipe_en_t      en;
    logic [PHASE_W-1:0] cos_phase;

    // Cosine is sine a quarter turn ahead, wrapping at a full turn
    assign cos_phase = phase + QUARTER_TURN;

    scti_pipe_ctl u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .en        (en)
    );

    scti_wave_path u_sine (
        .clk   (clk),
        .en    (en),
        .phase (phase),
        .value (sine_value)
    );

    scti_wave_path u_cosine (
        .clk   (clk),
        .en    (en),
        .phase (cos_phase),
        .value (cosine_value)
    );

    // Input is held off only when every stage is full and the output waits
    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && u_ctl.v1_reg && u_ctl.v2_reg && u_ctl.v3_reg)
    ) else $error("input stalled with room in the pipeline");

    // An accepted item lands in the first stage
    a_accept_enters: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> u_ctl.v1_reg
    ) else $error("accepted item did not enter stage 1");

    // Interpolated results stay inside the table's scaled range
    a_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (sine_value <= OUT_MAX && sine_value >= -OUT_MAX &&
                       cosine_value <= OUT_MAX && cosine_value >= -OUT_MAX)
    ) else $error("result out of range");

endmodule
